FILE: rtl/core/akdr_pkg.sv
// Shared types and constants for the analog key debounce and report builder.
// No dependencies; every other file imports this package.
package akdr_pkg;

  localparam int NUM_KEYS      = 5;
  localparam int REPORT_SLOTS  = 6;
  localparam int SAMPLE_BITS   = 12;
  localparam int CHANNELS      = 5;
  localparam int OUT_SLOTS     = 6;
  localparam int CODE_BITS     = 8;
  localparam int IVL_BITS      = 8;
  localparam int TICK_BITS     = IVL_BITS + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int COUNT_BITS    = $clog2(REPORT_SLOTS + 1);
  localparam int QDEPTH        = 2;
  localparam int QPTR_BITS     = $clog2(QDEPTH);

  typedef logic [SAMPLE_BITS-1:0]   level_t;
  typedef logic [IVL_BITS-1:0]      ivl_t;
  typedef logic [TICK_BITS-1:0]     tick_t;
  typedef logic [CHANNELS-1:0]      pattern_t;
  typedef logic [CODE_BITS-1:0]     code_t;
  typedef logic [COUNT_BITS-1:0]    count_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;
  typedef level_t [CHANNELS-1:0]    levels_t;
  typedef code_t  [CHANNELS-1:0]    codes_t;
  typedef code_t  [OUT_SLOTS-1:0]   slots_t;

  // One confirmed key change handed from front to back
  typedef struct packed {
    pattern_t pat;
    pattern_t diff;
  } change_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    slots_t slots;
    count_t count;
  } report_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_INTERVAL  = 3'd1,
    CFG_CODE0     = 3'd2,
    CFG_CODE1     = 3'd3,
    CFG_CODE2     = 3'd4,
    CFG_CODE3     = 3'd5,
    CFG_CODE4     = 3'd6
  } cfg_index_t;

  localparam level_t   THRESHOLD_RESET = 12'd1600;
  localparam ivl_t     INTERVAL_RESET  = 8'd5;
  localparam codes_t   CODES_RESET     = {8'd9, 8'd26, 8'd4, 8'd22, 8'd7};
  localparam pattern_t PATTERN_ALL_UP  = '1;

endpackage

FILE: rtl/core/akdr_front.sv
// Front end: threshold compare, debounce tick counter, change detection.
// Depends on akdr_pkg.
module akdr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  akdr_pkg::levels_t levels,
  input  akdr_pkg::level_t threshold,
  input  akdr_pkg::ivl_t   interval,
  output logic             push,
  output akdr_pkg::change_t change
);
  import akdr_pkg::*;

  tick_t    tick_count;
  pattern_t first_sample;
  pattern_t last_stable;

  pattern_t pat;
  ivl_t     iv;
  tick_t    tick_inc;
  logic     confirm;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      if (k < NUM_KEYS) begin
        pat[k] = levels[k] > threshold;
      end else begin
        pat[k] = 1'b1;
      end
    end
    iv       = (interval == '0) ? ivl_t'(1) : interval;
    tick_inc = tick_count + tick_t'(1);
    confirm  = tick_inc >= {iv, 1'b0};
    push     = accept && confirm && (first_sample == pat) && (pat != last_stable);
    change.pat  = pat;
    change.diff = pat ^ last_stable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      first_sample <= '0;
      last_stable  <= PATTERN_ALL_UP;
    end else if (accept) begin
      if (confirm) begin
        tick_count <= '0;
      end else begin
        tick_count <= tick_inc;
        if (tick_inc == {1'b0, iv}) begin
          first_sample <= pat;
        end
      end
      if (push) begin
        last_stable <= pat;
      end
    end
  end

endmodule

FILE: rtl/core/akdr_queue.sv
// Short FIFO of confirmed key changes between front and back.
// Depends on akdr_pkg.
module akdr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  akdr_pkg::change_t    wr_data,
  input  logic                 pop,
  output akdr_pkg::change_t    rd_data,
  output akdr_pkg::q_status_t  status
);
  import akdr_pkg::*;

  change_t                entries [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign rd_data      = entries[rd_ptr];
  assign status.full  = count == (QPTR_BITS+1)'(QDEPTH);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_BITS+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_BITS+1)'(1);
      end
    end
  end

endmodule

FILE: rtl/core/akdr_back.sv
// Back end: applies a key change to the report slots and holds the result.
// Depends on akdr_pkg.
module akdr_back (
  input  logic                clk,
  input  logic                rst,
  input  akdr_pkg::q_status_t status,
  input  akdr_pkg::change_t   head,
  input  akdr_pkg::codes_t    codes,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output akdr_pkg::slots_t    out_slots
);
  import akdr_pkg::*;

  report_t report;
  report_t report_next;

  // one key press or release; release of an absent code is a no-op
  function automatic report_t apply_key(report_t s, code_t code, logic up);
    report_t r;
    logic    found;
    count_t  idx;
    r     = s;
    found = 1'b0;
    idx   = '0;
    if (up) begin
      for (int j = 0; j < REPORT_SLOTS; j++) begin
        if (!found && (count_t'(j) < s.count) && (s.slots[j] == code)) begin
          found = 1'b1;
          idx   = count_t'(j);
        end
      end
      if (found) begin
        for (int j = 0; j < REPORT_SLOTS - 1; j++) begin
          if (count_t'(j) >= idx) begin
            r.slots[j] = s.slots[j+1];
          end
        end
        r.slots[REPORT_SLOTS-1] = '0;
        r.count = s.count - count_t'(1);
      end
    end else if (s.count < count_t'(REPORT_SLOTS)) begin
      r.slots[s.count] = code;
      r.count          = s.count + count_t'(1);
    end
    return r;
  endfunction

  assign pop = !status.empty && (!out_valid || out_ready);

  // channel 4 first, down to channel 0
  always_comb begin
    report_next = report;
    for (int k = CHANNELS - 1; k >= 0; k--) begin
      if (head.diff[k]) begin
        report_next = apply_key(report_next, codes[k], head.pat[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report    <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      report    <= report_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_slots <= report_next.slots;
    end
  end

endmodule

FILE: rtl/core/analog_key_debounce_report.sv
// Top level of the analog key debounce and 6-key report builder.
// Depends on akdr_pkg, akdr_front, akdr_queue and akdr_back.
//
// Takes one item of five 12-bit key levels per clock while in_ready is
// high and returns a six-slot key report whenever the debounced key
// pattern changes. Each level above the threshold register reads as key
// up. The pattern is sampled at tick interval and confirmed at twice that
// tick; a confirmed pattern that differs from the last one updates the
// slot list (presses append, releases remove and close the gap) and emits
// the six slots. Rate: one item per cycle sustained while the queue has
// room. The front end classifies an item in the cycle it is taken; a
// confirmed change waits in a two-entry queue and the back end applies
// all five channels of it together into the result register, which
// follows the queue. in_ready falls only when the queue is full, which
// needs the result register to be held by out_ready low. Configuration
// writes are meant for idle periods only; index 7 is ignored.
module analog_key_debounce_report (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [akdr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  akdr_pkg::cfg_data_t       cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  akdr_pkg::level_t          level_ch0,
  input  akdr_pkg::level_t          level_ch1,
  input  akdr_pkg::level_t          level_ch2,
  input  akdr_pkg::level_t          level_ch3,
  input  akdr_pkg::level_t          level_ch4,
  output logic                      out_valid,
  input  logic                      out_ready,
  output akdr_pkg::code_t           slot_0,
  output akdr_pkg::code_t           slot_1,
  output akdr_pkg::code_t           slot_2,
  output akdr_pkg::code_t           slot_3,
  output akdr_pkg::code_t           slot_4,
  output akdr_pkg::code_t           slot_5
);
  import akdr_pkg::*;

  // configuration registers
  level_t threshold;
  ivl_t   interval;
  codes_t codes;

  levels_t   levels;
  logic      accept;
  logic      push;
  logic      pop;
  change_t   change;
  change_t   head;
  q_status_t q_status;
  slots_t    out_slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      interval  <= INTERVAL_RESET;
      codes     <= CODES_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_INTERVAL:  interval  <= cfg_data[IVL_BITS-1:0];
        CFG_CODE0:     codes[0]  <= cfg_data[CODE_BITS-1:0];
        CFG_CODE1:     codes[1]  <= cfg_data[CODE_BITS-1:0];
        CFG_CODE2:     codes[2]  <= cfg_data[CODE_BITS-1:0];
        CFG_CODE3:     codes[3]  <= cfg_data[CODE_BITS-1:0];
        CFG_CODE4:     codes[4]  <= cfg_data[CODE_BITS-1:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  assign levels   = {level_ch4, level_ch3, level_ch2, level_ch1, level_ch0};
  // queue space is the only thing that holds the front back
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  akdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .levels    (levels),
    .threshold (threshold),
    .interval  (interval),
    .push      (push),
    .change    (change)
  );

  akdr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (change),
    .pop     (pop),
    .rd_data (head),
    .status  (q_status)
  );

  akdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .status    (q_status),
    .head      (head),
    .codes     (codes),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_slots (out_slots)
  );

  assign slot_0 = out_slots[0];
  assign slot_1 = out_slots[1];
  assign slot_2 = out_slots[2];
  assign slot_3 = out_slots[3];
  assign slot_4 = out_slots[4];
  assign slot_5 = out_slots[5];

endmodule

FILE: rtl/core/akdr_checker.sv
// Port-level checks for analog_key_debounce_report, bound to the top level.
// Depends on akdr_pkg.
module akdr_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input akdr_pkg::code_t slot_0
);
  import akdr_pkg::*;

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // the queue only fills while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(slot_0))
    else $error("result changed while stalled");

endmodule

bind analog_key_debounce_report akdr_checker u_akdr_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for analog_key_debounce_report: directed and random scan ticks
// are fed in, and each key report is checked slot by slot against a local prediction.
// Depends on akdr_pkg and the block's RTL; needs no other file.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import akdr_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int QUIET_LIMIT = 2000;   // cycles with no handshake before we give up
  localparam int SETTLE_GAP  = 8;      // covers a tick still in the block's queue

  // Level presets for the directed part, all taken against the reset threshold
  localparam level_t LV_TOP   = '1;
  localparam level_t LV_AT    = THRESHOLD_RESET;
  localparam level_t LV_ABOVE = THRESHOLD_RESET + 12'd1;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM} ready_mode_t;

  // One scan tick; drain makes the sender hold it back until all reports are in
  typedef struct packed {
    levels_t levels;
    logic    drain;
  } scan_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  cfg_index_t cfg_index = CFG_THRESHOLD;
  cfg_data_t  cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  level_t     level_ch0 = '0;
  level_t     level_ch1 = '0;
  level_t     level_ch2 = '0;
  level_t     level_ch3 = '0;
  level_t     level_ch4 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  code_t      slot_0, slot_1, slot_2, slot_3, slot_4, slot_5;

  analog_key_debounce_report dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .level_ch0 (level_ch0),
    .level_ch1 (level_ch1),
    .level_ch2 (level_ch2),
    .level_ch3 (level_ch3),
    .level_ch4 (level_ch4),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .slot_0    (slot_0),
    .slot_1    (slot_1),
    .slot_2    (slot_2),
    .slot_3    (slot_3),
    .slot_4    (slot_4),
    .slot_5    (slot_5)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of the debounce and
  // report state. Registers are only touched while the block is idle, so the
  // copy is updated at the moment the write is issued.
  // ---------------------------------------------------------------------------
  level_t   key_thr    = THRESHOLD_RESET;
  ivl_t     key_ivl    = INTERVAL_RESET;
  codes_t   key_codes  = CODES_RESET;
  tick_t    tick_cnt   = '0;
  pattern_t first_pat  = '0;
  pattern_t stable_pat = PATTERN_ALL_UP;
  code_t    slot_list [OUT_SLOTS] = '{default: '0};
  int       held_keys  = 0;

  scan_t    pending_scans [$];     // ticks waiting to be driven
  slots_t   expected_reports [$];  // reports predicted but not yet seen
  int       mismatch_count = 0;

  // Sender and receiver pacing, retuned per phase by the stimulus process
  int          gap_max       = 0;
  int          burst_left    = 1;
  int          gap_left      = 0;
  ready_mode_t ready_mode    = READY_ALWAYS;
  logic [15:0] ready_pattern = '1;
  logic [3:0]  ready_pos     = '0;

  pattern_t aim_pat = PATTERN_ALL_UP;  // pattern the generator is steering towards
  slots_t   report_want;               // driver side: freshly predicted report
  slots_t   report_seen;               // monitor side: oldest prediction
  int       quiet_cycles = 0;

  // Advance the debounce by one tick; returns 1 with the new report when the
  // confirmed pattern changed. Keys are walked from channel 4 down to 0, as
  // the order decides which slot each new press lands in.
  function automatic bit debounce_tick(input levels_t lv, output slots_t rpt);
    pattern_t pat;
    pattern_t diff;
    int       ivl;
    int       k;
    int       j;
    int       hit;
    pat = PATTERN_ALL_UP;   // channels past NUM_KEYS stay up
    rpt = '0;
    ivl = (key_ivl == 0) ? 1 : int'(key_ivl);   // a zero interval behaves as one
    for (k = 0; k < NUM_KEYS; k++)
      pat[k] = (lv[k] > key_thr);
    tick_cnt = tick_cnt + 1'b1;
    // The confirming sample also fires when the count has run past the end,
    // which happens after the interval was lowered mid-count.
    if (int'(tick_cnt) < 2 * ivl) begin
      if (int'(tick_cnt) == ivl)
        first_pat = pat;
      return 1'b0;
    end
    tick_cnt = '0;
    // Bounce between the two samples, or nothing new: no report
    if (first_pat != pat || pat == stable_pat)
      return 1'b0;
    diff = pat ^ stable_pat;
    for (k = CHANNELS - 1; k >= 0; k--) begin
      if (diff[k]) begin
        if (!pat[k]) begin
          // Press: append, silently dropped when the report is full
          if (held_keys < REPORT_SLOTS) begin
            slot_list[held_keys] = key_codes[k];
            held_keys++;
          end
        end else begin
          // Release: first matching occupied slot goes, the rest close up.
          // A code that is not held (codes rewritten meanwhile) changes nothing.
          hit = -1;
          for (j = 0; j < held_keys; j++)
            if (hit < 0 && slot_list[j] == key_codes[k])
              hit = j;
          if (hit >= 0) begin
            for (j = hit; j < REPORT_SLOTS - 1; j++)
              slot_list[j] = slot_list[j + 1];
            slot_list[REPORT_SLOTS - 1] = '0;
            held_keys--;
          end
        end
      end
    end
    stable_pat = pat;
    for (k = 0; k < OUT_SLOTS; k++)
      rpt[k] = (k < REPORT_SLOTS) ? slot_list[k] : '0;
    return 1'b1;
  endfunction

  function automatic void check_slot(string name, code_t want, code_t got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // A level that reads as the wanted key state under the current threshold,
  // now and then right on the boundary. With the threshold at full scale
  // nothing can read up, so the top level is returned.
  function automatic level_t level_for(bit up);
    if (up) begin
      if (key_thr == '1)
        return '1;
      if ($urandom_range(7, 0) == 0)
        return key_thr + 1'b1;
      return level_t'($urandom_range(4095, int'(key_thr) + 1));
    end
    if ($urandom_range(7, 0) == 0)
      return key_thr;
    return level_t'($urandom_range(int'(key_thr), 0));
  endfunction

  // Next target pattern: mostly one key at a time, sometimes all up or all
  // down, sometimes an arbitrary jump.
  function automatic pattern_t next_pattern(pattern_t cur);
    int roll;
    roll = $urandom_range(9, 0);
    if (roll < 5)
      return cur ^ (pattern_t'(1) << $urandom_range(CHANNELS - 1, 0));
    if (roll == 5)
      return PATTERN_ALL_UP;
    if (roll == 6)
      return '0;
    return cur ^ pattern_t'($urandom_range(31, 1));
  endfunction

  task automatic queue_levels(levels_t lv, int n);
    scan_t s;
    s.levels = lv;
    s.drain  = 1'b0;
    repeat (n) pending_scans.push_back(s);
  endtask

  // Hold a key pattern for a number of ticks, levels fresh each tick
  task automatic queue_pattern(pattern_t pat, int ticks, bit drain_first);
    scan_t s;
    int    k;
    for (int t = 0; t < ticks; t++) begin
      for (k = 0; k < CHANNELS; k++)
        s.levels[k] = level_for(pat[k]);
      s.drain = (t == 0) ? drain_first : 1'b0;
      pending_scans.push_back(s);
    end
  endtask

  // Random phase: mostly patterns held for three to four intervals, which
  // always spans a first and a confirming sample; the rest are short bounces
  // and raw noise across the full level range.
  task automatic run_random(int n_items, int drain_pct);
    scan_t s;
    int    queued;
    int    ivl;
    int    hold;
    int    roll;
    int    k;
    queued = 0;
    while (queued < n_items) begin
      ivl  = (key_ivl == 0) ? 1 : int'(key_ivl);
      roll = $urandom_range(99, 0);
      if (roll < 75) begin
        aim_pat = next_pattern(aim_pat);
        hold    = $urandom_range(4 * ivl, 3 * ivl);
        queue_pattern(aim_pat, hold, $urandom_range(99, 0) < drain_pct);
      end else if (roll < 88) begin
        hold = $urandom_range(ivl, 1);
        queue_pattern(pattern_t'($urandom_range(31, 0)), hold, 1'b0);
      end else begin
        hold = $urandom_range(4, 1);
        repeat (hold) begin
          for (k = 0; k < CHANNELS; k++)
            s.levels[k] = level_t'($urandom_range(4095, 0));
          s.drain = 1'b0;
          pending_scans.push_back(s);
        end
      end
      queued += hold;
    end
  endtask

  // Register write: one cycle with the enable high, then low again
  task automatic write_reg(cfg_index_t idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_data_t'(val);
    case (idx)
      CFG_THRESHOLD: key_thr = level_t'(val);
      CFG_INTERVAL:  key_ivl = ivl_t'(val);
      default:       key_codes[int'(idx) - int'(CFG_CODE0)] = code_t'(val);
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic randomise_codes(bit with_duplicate);
    int k;
    for (k = 0; k < CHANNELS; k++)
      write_reg(cfg_index_t'(int'(CFG_CODE0) + k), $urandom_range(255, 0));
    // Two channels sharing a code exercise removal of the first match
    if (with_duplicate)
      write_reg(CFG_CODE4, key_codes[0]);
  endtask

  // Wait until every tick is in and every report is out, then give the block
  // time to finish a tick that produced nothing.
  task automatic settle();
    while (pending_scans.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of ticks separated by random gaps. A tick is predicted at
  // the edge where it is taken, from the levels still on the pins.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (debounce_tick({level_ch4, level_ch3, level_ch2, level_ch1, level_ch0},
                          report_want))
          expected_reports.push_back(report_want);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_scans.size() != 0 &&
                     !(pending_scans[0].drain && expected_reports.size() != 0)) begin
          level_ch0 <= pending_scans[0].levels[0];
          level_ch1 <= pending_scans[0].levels[1];
          level_ch2 <= pending_scans[0].levels[2];
          level_ch3 <= pending_scans[0].levels[3];
          level_ch4 <= pending_scans[0].levels[4];
          void'(pending_scans.pop_front());
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(12, 1);
            gap_left   = (gap_max > 0) ? $urandom_range(gap_max, 1) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each report taken is checked against the oldest prediction.
  // out_ready follows the phase's stall scheme.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("report with no prediction waiting: %02h %02h %02h %02h %02h %02h",
                 slot_0, slot_1, slot_2, slot_3, slot_4, slot_5);
          mismatch_count++;
        end else begin
          report_seen = expected_reports.pop_front();
          check_slot("slot_0", report_seen[0], slot_0);
          check_slot("slot_1", report_seen[1], slot_1);
          check_slot("slot_2", report_seen[2], slot_2);
          check_slot("slot_3", report_seen[3], slot_3);
          check_slot("slot_4", report_seen[4], slot_4);
          check_slot("slot_5", report_seen[5], slot_5);
        end
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_PATTERN: begin
          out_ready <= ready_pattern[ready_pos];
          ready_pos <= ready_pos + 1'b1;
        end
        default: out_ready <= ($urandom_range(2, 0) == 0);
      endcase
    end
  end

  // Watchdog: too long without any handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, phase by phase; registers change only between phases.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Zero interval acts as one, so each pair of ticks is a
    // first sample and its confirmation, aligned from reset. Channels 1 and 3
    // share a code, channel 0 reports code zero.
    gap_max    = 3;
    ready_mode = READY_RANDOM;
    write_reg(CFG_INTERVAL, 0);
    write_reg(CFG_CODE0, 0);
    write_reg(CFG_CODE1, 255);
    write_reg(CFG_CODE2, 22);
    write_reg(CFG_CODE3, 255);
    write_reg(CFG_CODE4, 9);
    queue_levels({5{12'd0}}, 2);                            // every key down
    queue_levels({5{LV_TOP}}, 2);                           // all up, duplicates removed
    queue_levels({5{LV_TOP}}, 2);                           // stable, unchanged: silent
    queue_levels({{4{LV_ABOVE}}, LV_AT}, 2);                // level equal to threshold is down
    queue_levels({LV_TOP, LV_TOP, LV_TOP, 12'd0, LV_AT}, 1);  // bounce: samples differ
    queue_levels({{4{LV_TOP}}, LV_AT}, 1);
    queue_levels({LV_TOP, 12'd0, LV_TOP, 12'd0, LV_ABOVE}, 2);  // press both twins
    queue_levels({LV_TOP, LV_TOP, LV_TOP, 12'd1, LV_TOP}, 2);   // release one twin
    queue_levels({12'd0, LV_TOP, LV_AT, 12'd0, LV_TOP}, 2);
    queue_levels({LV_ABOVE, 12'h800, 12'h7FF, LV_AT, 12'h555}, 2);
    queue_levels({5{12'hAAA}}, 2);
    settle();

    // Same codes, short interval, random pacing on both sides
    aim_pat = stable_pat;
    write_reg(CFG_INTERVAL, 2);
    run_random(150, 0);
    settle();

    // Codes rewritten while keys may be held: releases of codes no longer
    // present. Threshold at zero, so only a zero level reads down.
    gap_max       = 6;
    ready_mode    = READY_PATTERN;
    ready_pattern = 16'($urandom_range(65535, 0)) | 16'h0001;
    randomise_codes(1'b0);
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_INTERVAL, 1);
    run_random(100, 0);
    settle();

    // Threshold at full scale: every key reads down
    write_reg(CFG_THRESHOLD, 4095);
    run_random(40, 0);
    settle();

    // Longest interval: one pattern held through a first and a confirming
    // sample; the count starts at most one tick in.
    gap_max    = 2;
    ready_mode = READY_RANDOM;
    write_reg(CFG_THRESHOLD, $urandom_range(3000, 500));
    write_reg(CFG_INTERVAL, 255);
    aim_pat = next_pattern(aim_pat);
    queue_pattern(aim_pat, 2 * 255 + 2 + $urandom_range(10, 0), 1'b0);
    settle();

    // Interval cut back to one with the counter part-way: the count is past
    // the end. No idling on either side, twin codes again.
    gap_max    = 0;
    ready_mode = READY_ALWAYS;
    randomise_codes(1'b1);
    write_reg(CFG_INTERVAL, 1);
    write_reg(CFG_THRESHOLD, $urandom_range(4094, 1));
    run_random(150, 0);
    settle();

    // Heavy receiver stalls to back the block up; the sender also stops now
    // and then until every report is home.
    gap_max       = 2;
    ready_mode    = READY_PATTERN;
    ready_pattern = 16'h0001;
    write_reg(CFG_THRESHOLD, 2048);
    write_reg(CFG_INTERVAL, 3);
    aim_pat = next_pattern(aim_pat);
    queue_pattern(aim_pat, 12, 1'b1);
    run_random(150, 10);
    settle();

    // Mixed pacing, moderate interval, fresh codes
    gap_max    = 10;
    ready_mode = READY_RANDOM;
    randomise_codes($urandom_range(1, 0));
    write_reg(CFG_THRESHOLD, $urandom_range(4095, 0));
    write_reg(CFG_INTERVAL, $urandom_range(10, 2));
    run_random(120, 5);
    settle();

    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/akdr_pkg.sv
rtl/core/akdr_front.sv
rtl/core/akdr_queue.sv
rtl/core/akdr_back.sv
rtl/core/analog_key_debounce_report.sv
rtl/core/akdr_checker.sv
tb/tb_top.sv
